// ===== design/pbenc_pkg.sv =====
package pbenc_pkg;

    // Input beat: one raw byte of the stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } pbenc_in_t;

    // Result beat: packed encoded bytes, first byte in the top lane
    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  out_count;
        logic        last_of_burst;
    } pbenc_out_t;

    localparam int          WORD_W   = 64;
    localparam logic [7:0]  END_CODE = 8'd128;
    localparam logic [8:0]  RUN_BASE = 9'd257;

    // Source of the byte pushed into the packer
    localparam logic [2:0] SEL_LIT_HDR  = 3'd0;
    localparam logic [2:0] SEL_LIT_DATA = 3'd1;
    localparam logic [2:0] SEL_RUN_HDR  = 3'd2;
    localparam logic [2:0] SEL_RUN_BYTE = 3'd3;
    localparam logic [2:0] SEL_END      = 3'd4;

    typedef struct packed {
        logic       take_in;
        logic       held_load;
        logic       rc_set1;
        logic       rc_set2;
        logic       rc_inc;
        logic       lit_write;
        logic       lit_clear;
        logic       rd_start;
        logic       rd_issue;
        logic       rd_next;
        logic       clear_all;
        logic       push;
        logic [2:0] push_sel;
        logic       close;
    } pbenc_cmd_t;

    typedef struct packed {
        logic fin;
        logic rc_zero;
        logic rc_one;
        logic b_eq_held;
        logic rc_lt_max;
        logic lit_empty;
        logic lit_full_next;
        logic rd_last;
    } pbenc_dp_sts_t;

    typedef struct packed {
        logic push_ready;
        logic close_ready;
    } pbenc_pk_sts_t;

endpackage

// ===== design/packbits_encoder_core.sv =====
// PackBits run-length encoder.
// Input channel (s_valid/s_ready/s_data): one raw byte per beat; final_byte
// marks the end of a stream, which flushes all pending bytes and appends the
// end code 128. The next beat then starts a new stream.
// Result channel (m_valid/m_ready/m_data): encoded bytes packed OUT_LANES per
// beat, first byte in the top lane, out_count lanes valid, last_of_burst set on
// the final beat caused by one input beat. An input that completes nothing
// yields no result beat.
// One byte is handled at a time, held in a controller loop. A byte that only
// holds, extends a run or adds a literal passes through the idle, main and
// finish states. Emitting a run adds a header push and a byte push; flushing
// a literal block adds a header push, then a literal memory read before each
// pushed byte; the end code adds its push and a close. A result beat is loaded
// into the output register when the next byte is packed or the burst closes.
// Reset (aresetn low, synchronous) empties the run and literal state and the
// output register; no clearing pass is needed. A stalled receiver holds the
// output register; the packer keeps filling its staging word, the controller
// waits to push once both are full and to close while both hold bytes.
module packbits_encoder_core #(
    parameter int MAX_BLOCK = 128,
    parameter int OUT_LANES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pbenc_pkg::pbenc_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pbenc_pkg::pbenc_out_t m_data
);

    pbenc_pkg::pbenc_cmd_t    cmd;
    pbenc_pkg::pbenc_dp_sts_t dp_sts;
    pbenc_pkg::pbenc_pk_sts_t pk_sts;
    logic [7:0]               push_byte;

    pbenc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .dp_sts  (dp_sts),
        .pk_sts  (pk_sts),
        .cmd     (cmd)
    );

    pbenc_dp #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .cmd       (cmd),
        .sts       (dp_sts),
        .push_byte (push_byte)
    );

    pbenc_pack #(
        .OUT_LANES (OUT_LANES)
    ) u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .push_byte (push_byte),
        .sts       (pk_sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== design/pbenc_dp.sv =====
module pbenc_dp #(
    parameter int MAX_BLOCK = 128
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pbenc_pkg::pbenc_in_t   in_data,
    input  pbenc_pkg::pbenc_cmd_t  cmd,
    output pbenc_pkg::pbenc_dp_sts_t sts,
    output logic [7:0]             push_byte
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int IDX_W = $clog2(MAX_BLOCK);

    logic [7:0]       lit_mem [MAX_BLOCK];
    logic [7:0]       byte_reg;
    logic             fin_reg;
    logic [7:0]       held_reg, held_next;
    logic [CNT_W-1:0] rc_reg, rc_next;
    logic [CNT_W-1:0] lit_cnt_reg, lit_cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       rd_data_reg;
    logic [CNT_W-1:0] idx_ext;

    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            byte_reg <= in_data.data_byte;
            fin_reg  <= in_data.final_byte;
        end
        if (cmd.lit_write) begin
            lit_mem[lit_cnt_reg[IDX_W-1:0]] <= held_reg;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= lit_mem[idx_reg];
        end
        idx_reg <= idx_next;
    end

    always_comb begin
        held_next = held_reg;
        if (cmd.held_load) held_next = byte_reg;
        if (cmd.clear_all) held_next = 8'd0;

        rc_next = rc_reg;
        if (cmd.rc_set1) rc_next = CNT_W'(1);
        if (cmd.rc_set2) rc_next = CNT_W'(2);
        if (cmd.rc_inc)  rc_next = rc_reg + CNT_W'(1);
        if (cmd.clear_all) rc_next = '0;

        lit_cnt_next = lit_cnt_reg;
        if (cmd.lit_write) lit_cnt_next = lit_cnt_reg + CNT_W'(1);
        if (cmd.lit_clear || cmd.clear_all) lit_cnt_next = '0;

        idx_next = idx_reg;
        if (cmd.rd_start) idx_next = '0;
        if (cmd.rd_next)  idx_next = idx_reg + IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= 8'd0;
            rc_reg      <= '0;
            lit_cnt_reg <= '0;
        end else begin
            held_reg    <= held_next;
            rc_reg      <= rc_next;
            lit_cnt_reg <= lit_cnt_next;
        end
    end

    assign idx_ext = CNT_W'(idx_reg);

    always_comb begin
        sts.fin           = fin_reg;
        sts.rc_zero       = (rc_reg == '0);
        sts.rc_one        = (rc_reg == CNT_W'(1));
        sts.b_eq_held     = (byte_reg == held_reg);
        sts.rc_lt_max     = (rc_reg < CNT_W'(MAX_BLOCK));
        sts.lit_empty     = (lit_cnt_reg == '0);
        sts.lit_full_next = (lit_cnt_reg == CNT_W'(MAX_BLOCK - 1));
        sts.rd_last       = ((idx_ext + CNT_W'(1)) == lit_cnt_reg);
    end

    always_comb begin
        case (cmd.push_sel)
            pbenc_pkg::SEL_LIT_HDR:  push_byte = 8'(lit_cnt_reg) - 8'd1;
            pbenc_pkg::SEL_LIT_DATA: push_byte = rd_data_reg;
            pbenc_pkg::SEL_RUN_HDR:  push_byte = 8'(pbenc_pkg::RUN_BASE - 9'(rc_reg));
            pbenc_pkg::SEL_RUN_BYTE: push_byte = held_reg;
            pbenc_pkg::SEL_END:      push_byte = pbenc_pkg::END_CODE;
            default:                 push_byte = 8'd0;
        endcase
    end

endmodule

// ===== design/pbenc_pack.sv =====
module pbenc_pack #(
    parameter int OUT_LANES = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pbenc_pkg::pbenc_cmd_t    cmd,
    input  logic [7:0]               push_byte,
    output pbenc_pkg::pbenc_pk_sts_t sts,
    output logic                     m_valid,
    input  logic                     m_ready,
    output pbenc_pkg::pbenc_out_t    m_data
);

    localparam int LC_W = $clog2(OUT_LANES + 1);
    localparam int W    = pbenc_pkg::WORD_W;

    logic [W-1:0]          acc_reg, acc_next;
    logic [LC_W-1:0]       acc_cnt_reg, acc_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    pbenc_pkg::pbenc_out_t m_data_reg, m_data_next;
    logic                  out_free;
    logic                  acc_full;
    logic [LC_W-1:0]       lane;

    assign out_free = !m_valid_reg || m_ready;
    assign acc_full = (acc_cnt_reg == LC_W'(OUT_LANES));

    assign sts.push_ready  = !acc_full || out_free;
    assign sts.close_ready = (acc_cnt_reg == '0) || out_free;

    always_comb begin
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        lane         = acc_full ? '0 : acc_cnt_reg;

        if (cmd.push) begin
            // ship a full word lazily, only once another byte follows it
            if (acc_full) begin
                m_data_next.out_bytes     = acc_reg;
                m_data_next.out_count     = 4'(acc_cnt_reg);
                m_data_next.last_of_burst = 1'b0;
                m_valid_next              = 1'b1;
            end
            if (acc_full || acc_cnt_reg == '0) begin
                acc_next = '0;
            end
            for (int k = 0; k < OUT_LANES; k++) begin
                if (lane == LC_W'(k)) begin
                    acc_next[8*(OUT_LANES-1-k) +: 8] = push_byte;
                end
            end
            acc_cnt_next = lane + LC_W'(1);
        end else if (cmd.close && acc_cnt_reg != '0) begin
            m_data_next.out_bytes     = acc_reg;
            m_data_next.out_count     = 4'(acc_cnt_reg);
            m_data_next.last_of_burst = 1'b1;
            m_valid_next              = 1'b1;
            acc_cnt_next              = '0;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_cnt_reg <= acc_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/pbenc_ctrl.sv =====
module pbenc_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  pbenc_pkg::pbenc_dp_sts_t dp_sts,
    input  pbenc_pkg::pbenc_pk_sts_t pk_sts,
    output pbenc_pkg::pbenc_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAIN  = 4'd1;
    localparam logic [3:0] ST_LHDR  = 4'd2;
    localparam logic [3:0] ST_LRD   = 4'd3;
    localparam logic [3:0] ST_LDAT  = 4'd4;
    localparam logic [3:0] ST_RHDR  = 4'd5;
    localparam logic [3:0] ST_RBYT  = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;
    localparam logic [3:0] ST_END   = 4'd8;
    localparam logic [3:0] ST_CLOSE = 4'd9;

    logic [3:0] state_reg, state_next;
    // 0 while handling the byte itself, 1 while flushing at end of stream
    logic       phase_reg, phase_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        s_ready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    phase_next  = 1'b0;
                    state_next  = ST_MAIN;
                end
            end
            ST_MAIN: begin
                if (dp_sts.rc_zero) begin
                    cmd.held_load = 1'b1;
                    cmd.rc_set1   = 1'b1;
                    state_next    = ST_FIN;
                end else if (dp_sts.rc_one) begin
                    if (dp_sts.b_eq_held) begin
                        // a run starts: flush any pending literals first
                        cmd.rc_set2 = 1'b1;
                        state_next  = dp_sts.lit_empty ? ST_FIN : ST_LHDR;
                    end else begin
                        cmd.lit_write = 1'b1;
                        cmd.held_load = 1'b1;
                        state_next    = dp_sts.lit_full_next ? ST_LHDR : ST_FIN;
                    end
                end else if (dp_sts.b_eq_held && dp_sts.rc_lt_max) begin
                    cmd.rc_inc = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_RHDR;
                end
            end
            ST_LHDR: begin
                if (pk_sts.push_ready) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = pbenc_pkg::SEL_LIT_HDR;
                    cmd.rd_start = 1'b1;
                    state_next   = ST_LRD;
                end
            end
            ST_LRD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LDAT;
            end
            ST_LDAT: begin
                cmd.push_sel = pbenc_pkg::SEL_LIT_DATA;
                if (pk_sts.push_ready) begin
                    cmd.push    = 1'b1;
                    cmd.rd_next = 1'b1;
                    if (dp_sts.rd_last) begin
                        cmd.lit_clear = 1'b1;
                        state_next    = phase_reg ? ST_END : ST_FIN;
                    end else begin
                        state_next = ST_LRD;
                    end
                end
            end
            ST_RHDR: begin
                cmd.push_sel = pbenc_pkg::SEL_RUN_HDR;
                if (pk_sts.push_ready) begin
                    cmd.push   = 1'b1;
                    state_next = ST_RBYT;
                end
            end
            ST_RBYT: begin
                cmd.push_sel = pbenc_pkg::SEL_RUN_BYTE;
                if (pk_sts.push_ready) begin
                    cmd.push = 1'b1;
                    if (phase_reg) begin
                        state_next = ST_END;
                    end else begin
                        // the breaking byte becomes the new held byte
                        cmd.held_load = 1'b1;
                        cmd.rc_set1   = 1'b1;
                        state_next    = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!dp_sts.fin) begin
                    if (pk_sts.close_ready) begin
                        cmd.close  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    phase_next = 1'b1;
                    if (dp_sts.rc_one) begin
                        cmd.lit_write = 1'b1;
                        state_next    = ST_LHDR;
                    end else begin
                        state_next = ST_RHDR;
                    end
                end
            end
            ST_END: begin
                cmd.push_sel = pbenc_pkg::SEL_END;
                if (pk_sts.push_ready) begin
                    cmd.push   = 1'b1;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (pk_sts.close_ready) begin
                    cmd.close     = 1'b1;
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== test/tb_packbits_encoder_core.sv =====
`timescale 1ns / 1ps

module tb_packbits_encoder_core;

    localparam int MAX_BLOCK   = 128;
    localparam int OUT_LANES   = 8;
    localparam int TAIL_CYCLES = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    pbenc_pkg::pbenc_in_t  s_data     = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    pbenc_pkg::pbenc_out_t m_data;
    logic                  hold_start = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    // encoder state mirror
    logic [7:0] lit_mem [MAX_BLOCK];
    int         lit_n = 0;
    logic [7:0] held = '0;
    int         rep_n = 0;
    logic [7:0] burst_bytes [$];
    pbenc_pkg::pbenc_out_t expected_words [$];

    packbits_encoder_core #(
        .MAX_BLOCK(MAX_BLOCK),
        .OUT_LANES(OUT_LANES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("packbits_encoder_core test failed");
            $finish;
        end
    end

    function automatic void queue_byte(logic [7:0] v);
        burst_bytes.insert(burst_bytes.size(), v);
    endfunction

    function automatic void lit_flush();
        if (lit_n == 0)
            return;
        queue_byte(8'(lit_n - 1));
        for (int i = 0; i < lit_n; i++)
            queue_byte(lit_mem[i]);
        lit_n = 0;
    endfunction

    function automatic void lit_add(logic [7:0] b);
        if (lit_n < MAX_BLOCK) begin
            lit_mem[lit_n] = b;
            lit_n++;
        end
        if (lit_n >= MAX_BLOCK)
            lit_flush();
    endfunction

    function automatic void run_emit();
        queue_byte(8'(pbenc_pkg::RUN_BASE - 9'(rep_n)));
        queue_byte(held);
    endfunction

    function automatic void encode_byte(logic [7:0] b, logic fin);
        pbenc_pkg::pbenc_out_t w;
        int                    pos;
        int                    cnt;
        burst_bytes.delete();
        if (rep_n == 0) begin
            held = b;
            rep_n = 1;
        end else if (rep_n == 1) begin
            if (b == held) begin
                lit_flush();
                rep_n = 2;
            end else begin
                lit_add(held);
                held = b;
            end
        end else if (b == held && rep_n < MAX_BLOCK) begin
            rep_n++;
        end else begin
            run_emit();
            held = b;
            rep_n = 1;
        end
        if (fin) begin
            if (rep_n == 1) begin
                lit_add(held);
                lit_flush();
            end else begin
                lit_flush();
                run_emit();
            end
            queue_byte(pbenc_pkg::END_CODE);
            lit_n = 0;
            held = '0;
            rep_n = 0;
        end
        // pack the burst into result words, first byte in the top lane
        pos = 0;
        while (pos < burst_bytes.size()) begin
            cnt = burst_bytes.size() - pos;
            if (cnt > OUT_LANES)
                cnt = OUT_LANES;
            w = '0;
            for (int k = 0; k < cnt; k++)
                w.out_bytes[8*(OUT_LANES-1-k) +: 8] = burst_bytes[pos+k];
            pos += cnt;
            w.out_count = 4'(cnt);
            w.last_of_burst = (pos >= burst_bytes.size());
            expected_words.insert(expected_words.size(), w);
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        err_count++;
    endtask

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        static int hold_left = 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else if (hold_start) begin
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        pbenc_pkg::pbenc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected beat", m_data.out_bytes, '0);
            end else begin
                want = expected_words.pop_front();
                if (m_data.out_bytes !== want.out_bytes)
                    report_mismatch("out_bytes", m_data.out_bytes, want.out_bytes);
                if (m_data.out_count !== want.out_count)
                    report_mismatch("out_count", 64'(m_data.out_count), 64'(want.out_count));
                if (m_data.last_of_burst !== want.last_of_burst)
                    report_mismatch("last_of_burst", 64'(m_data.last_of_burst),
                                    64'(want.last_of_burst));
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pbenc_pkg::pbenc_in_t'{data_byte: b, final_byte: fin};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        encode_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (expected_words.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_single_byte_streams();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_short_runs();
        send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b1);
        repeat (2) send_byte(8'h55, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_literal_then_run();
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        repeat (3) send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b1);
    endtask

    task automatic test_final_cases();
        // final byte differs from the held byte while a literal is pending
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b1);
        // final byte completes a run after a literal
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h20, 1'b1);
        // final byte breaks a run
        send_byte(8'h07, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h08, 1'b1);
    endtask

    task automatic test_full_literal();
        logic [7:0] b;
        logic [7:0] prev;
        prev = 8'h00;
        // the block fills as the final byte arrives; the final byte follows alone
        for (int i = 0; i < MAX_BLOCK + 1; i++) begin
            do b = 8'($urandom); while (b == prev);
            send_byte(b, i == MAX_BLOCK);
            prev = b;
        end
    endtask

    task automatic test_full_run();
        // a run past the cap splits, the extra byte becomes the held byte
        repeat (MAX_BLOCK) send_byte(8'h5A, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_pressure();
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        // pairs of equal bytes keep emitting runs while the receiver holds off
        for (int i = 0; i < 16; i++)
            send_byte(8'((i / 2) * 7), i == 15);
        send_byte(8'h33, 1'b1);
    endtask

    task automatic send_random_stream();
        int         n;
        int         kind;
        logic [7:0] b;
        logic [7:0] prev;
        kind = $urandom_range(9);
        n = $urandom_range(1, 14);
        prev = 8'($urandom);
        for (int i = 0; i < n; i++) begin
            case (kind)
                0: b = (i < n - 2) ? prev : 8'($urandom);
                1: do b = 8'($urandom); while (b == prev);
                default: begin
                    if ($urandom_range(1))
                        b = prev;
                    else if ($urandom_range(3) == 0)
                        b = $urandom_range(1) ? 8'hFF : 8'h00;
                    else
                        b = 8'($urandom);
                end
            endcase
            send_byte(b, i == n - 1);
            prev = b;
        end
    endtask

    task automatic test_random_streams(int send_pct, int recv_pct);
        int start;
        set_idling(send_pct, recv_pct);
        start = bytes_sent;
        while (bytes_sent - start < 10)
            send_random_stream();
        wait_quiet();
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(0, 0);
        test_single_byte_streams();
        test_short_runs();
        test_literal_then_run();
        test_final_cases();
        wait_quiet();

        set_idling(6, 45);
        test_full_literal();
        test_full_run();
        wait_quiet();

        set_idling(0, 0);
        test_pressure();
        wait_quiet();

        test_random_streams(0, 0);
        test_random_streams(45, 0);
        test_random_streams(0, 45);
        test_random_streams(6, 6);

        if (expected_words.size() != 0)
            report_mismatch("beats never arrived", 64'(expected_words.size()), '0);
        if (err_count == 0)
            $display("packbits_encoder_core test passed");
        else
            $display("packbits_encoder_core test failed");
        $finish;
    end

endmodule

// ===== packbits_encoder_core.f =====
design/pbenc_pkg.sv
design/pbenc_dp.sv
design/pbenc_pack.sv
design/pbenc_ctrl.sv
design/packbits_encoder_core.sv
test/tb_packbits_encoder_core.sv
